>>> design/http_chunked_decoder_defines.svh
// assertion macros for the chunked body decoder checker
// no dependencies; included by the checker file
`ifndef HTTP_CHUNKED_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_DECODER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define CHD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("chunked decoder check failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define CHD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chunked decoder check failed");

`endif

>>> design/chd_pkg.sv
// shared types and constants for the chunked body decoder
// no dependencies; used by chd_core, chd_outq and the top level
package chd_pkg;

    localparam int BYTE_W      = 8;
    localparam int OUT_COUNT_W = 24;

    localparam logic [BYTE_W-1:0]      CH_CR         = 8'h0D;
    localparam logic [BYTE_W-1:0]      CH_LF         = 8'h0A;
    localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = '1;

    // results of one accepted input transfer
    typedef struct packed {
        logic                   data_vld;
        logic [BYTE_W-1:0]      data;
        logic                   stat_vld;
        logic                   stat_incomplete;
        logic [OUT_COUNT_W-1:0] stat_count;
    } t_push;

    // one queued result transfer
    typedef struct packed {
        logic [BYTE_W-1:0]      data;
        logic                   last;
        logic                   status;
        logic [OUT_COUNT_W-1:0] count;
    } t_result;

endpackage

>>> design/chd_core.sv
// per-byte chunk parser: phase, size, totals and line-end tracking
// depends on chd_pkg
module chd_core
    import chd_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output t_push             o_push
);

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SIZE_REST,
        PH_DATA,
        PH_DATA_END,
        PH_TRAILER,
        PH_DONE
    } t_phase;

    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_left, n_left;
    logic [COUNT_BITS-1:0] r_committed, n_committed;
    logic [COUNT_BITS-1:0] r_pending, n_pending;
    logic                  r_prev_cr, n_prev_cr;

    logic                  w_crlf;
    logic                  w_is_cr;
    logic                  w_hex_ok;
    logic [3:0]            w_hex_val;
    logic [COUNT_BITS:0]   w_sum;
    logic [31:0]           w_c32;

    always_comb begin
        w_hex_ok  = 1'b1;
        w_hex_val = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            w_hex_val = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            w_hex_val = 4'(i_byte - 8'h37);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            w_hex_val = 4'(i_byte - 8'h57);
        end else begin
            w_hex_ok  = 1'b0;
        end
    end

    assign w_crlf  = r_prev_cr && (i_byte == CH_LF);
    assign w_is_cr = (i_byte == CH_CR);
    assign w_sum   = {1'b0, r_committed} + {1'b0, r_pending};

    always_comb begin
        n_phase     = r_phase;
        n_left      = r_left;
        n_committed = r_committed;
        n_pending   = r_pending;
        n_prev_cr   = w_is_cr;
        unique case (r_phase)
            PH_SIZE: begin
                if (w_hex_ok) begin
                    n_prev_cr = 1'b0;
                    if (|r_left[COUNT_BITS-1 -: 4]) begin
                        n_left = CountMax;
                    end else begin
                        n_left = {r_left[COUNT_BITS-5:0], w_hex_val};
                    end
                end else begin
                    n_phase = PH_SIZE_REST;
                end
            end
            PH_SIZE_REST: begin
                if (w_crlf) begin
                    n_prev_cr = 1'b0;
                    if (r_left == '0) begin
                        n_phase = PH_TRAILER;
                    end else begin
                        n_phase   = PH_DATA;
                        n_pending = '0;
                    end
                end
            end
            PH_DATA: begin
                n_prev_cr = 1'b0;
                n_pending = (r_pending == CountMax) ? r_pending
                                                    : r_pending + COUNT_BITS'(1);
                if (r_left != '0) begin
                    n_left = r_left - COUNT_BITS'(1);
                end
                if (r_left <= COUNT_BITS'(1)) begin
                    n_phase = PH_DATA_END;
                end
            end
            PH_DATA_END: begin
                if (w_crlf) begin
                    n_prev_cr   = 1'b0;
                    n_committed = w_sum[COUNT_BITS] ? CountMax : w_sum[COUNT_BITS-1:0];
                    n_pending   = '0;
                    n_left      = '0;
                    n_phase     = PH_SIZE;
                end
            end
            PH_TRAILER: begin
                if (w_crlf) begin
                    n_prev_cr = 1'b0;
                    n_phase   = PH_DONE;
                end
            end
            default: begin
                n_prev_cr = 1'b0;
            end
        endcase
    end

    assign w_c32 = 32'(n_committed);

    always_comb begin
        o_push.data_vld        = i_fire && (r_phase == PH_DATA);
        o_push.data            = i_byte;
        o_push.stat_vld        = i_fire && i_last;
        o_push.stat_incomplete = (n_phase != PH_DONE);
        o_push.stat_count      = (w_c32 > 32'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                             : w_c32[OUT_COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIZE;
            r_left      <= '0;
            r_committed <= '0;
            r_pending   <= '0;
            r_prev_cr   <= 1'b0;
        end else if (i_fire) begin
            if (i_last) begin
                r_phase     <= PH_SIZE;
                r_left      <= '0;
                r_committed <= '0;
                r_pending   <= '0;
                r_prev_cr   <= 1'b0;
            end else begin
                r_phase     <= n_phase;
                r_left      <= n_left;
                r_committed <= n_committed;
                r_pending   <= n_pending;
                r_prev_cr   <= n_prev_cr;
            end
        end
    end

endmodule

>>> design/chd_outq.sv
// four-entry result queue taking up to two results per input transfer
// depends on chd_pkg
module chd_outq
    import chd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_push                  i_push,
    output logic                   o_full,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [BYTE_W-1:0]      o_byte,
    output logic                   o_last,
    output logic                   o_status,
    output logic [OUT_COUNT_W-1:0] o_count
);

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    t_result             r_mem [Depth];
    logic [PtrW-1:0]     r_wr, r_rd;
    logic [CntW-1:0]     r_cnt;

    t_result             w_data_ent;
    t_result             w_stat_ent;
    t_result             w_ent0;
    logic [1:0]          w_num;
    logic                w_pop;
    logic [PtrW-1:0]     w_wr1;
    t_result             w_head;

    always_comb begin
        w_data_ent        = '0;
        w_data_ent.data   = i_push.data;
        w_stat_ent        = '0;
        w_stat_ent.last   = 1'b1;
        w_stat_ent.status = i_push.stat_incomplete;
        w_stat_ent.count  = i_push.stat_count;
        w_ent0            = i_push.data_vld ? w_data_ent : w_stat_ent;
        w_num             = 2'(i_push.data_vld) + 2'(i_push.stat_vld);
    end

    assign w_wr1   = r_wr + PtrW'(1);
    assign w_pop   = (r_cnt != '0) && !i_stall;
    assign w_head  = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt > CntW'(Depth - 2));
    assign o_byte   = w_head.data;
    assign o_last   = w_head.last;
    assign o_status = w_head.status;
    assign o_count  = w_head.count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_num != 2'd0) begin
                r_mem[r_wr] <= w_ent0;
            end
            if (w_num == 2'd2) begin
                r_mem[w_wr1] <= w_stat_ent;
            end
            r_wr  <= r_wr + PtrW'(w_num);
            if (w_pop) begin
                r_rd <= r_rd + PtrW'(1);
            end
            r_cnt <= r_cnt + CntW'(w_num) - CntW'(w_pop);
        end
    end

endmodule

>>> design/http_chunked_decoder.sv
// chunked transfer body decoder, top level
// depends on chd_pkg, chd_core and chd_outq
//
// input channel: one encoded byte per transfer on i_in_byte, i_in_last flags the
// buffer's final byte. output channel: decoded payload bytes with o_out_last low,
// and after the final input byte a status transfer with o_out_last high,
// o_out_status (0 complete, 1 incomplete) and o_out_count (bytes of closed chunks).
// the parser updates its state in the cycle a byte is taken; results are
// registered into a four-entry queue before they show on the output.
// one input byte per cycle is taken while the queue holds at most two results;
// a payload byte flagged last yields two results, the byte and then the status,
// so that case needs two output transfers. o_in_stall rises when the queue is near
// full, which is what stalls on the output side push back to the input.
// reset (synchronous, active low) empties the queue and returns the parser to
// reading a size line; the parser also returns there after each byte flagged last.
module http_chunked_decoder
    import chd_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [BYTE_W-1:0]      i_in_byte,
    input  logic                   i_in_last,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_out_last,
    output logic                   o_out_status,
    output logic [OUT_COUNT_W-1:0] o_out_count
);

    logic  w_fire;
    logic  w_full;
    t_push w_push;

    assign o_in_stall = w_full;
    assign w_fire     = i_in_valid && !w_full;

    chd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .o_push  (w_push)
    );

    chd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_full   (w_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_byte   (o_out_byte),
        .o_last   (o_out_last),
        .o_status (o_out_status),
        .o_count  (o_out_count)
    );

endmodule

>>> design/chd_checker.sv
// port-level checks for the chunked body decoder, bound to the top level
// depends on chd_pkg and http_chunked_decoder_defines.svh
`include "http_chunked_decoder_defines.svh"

module chd_checker
    import chd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [BYTE_W-1:0]      o_out_byte,
    input logic                   o_out_last,
    input logic                   o_out_status,
    input logic [OUT_COUNT_W-1:0] o_out_count
);

    logic                          w_pay_zero;
    logic [BYTE_W+OUT_COUNT_W+1:0] w_out_word;

    assign w_pay_zero = !o_out_status && (o_out_count == '0);
    assign w_out_word = {o_out_byte, o_out_last, o_out_status, o_out_count};

    `CHD_ASSERT_NOW(a_status_byte_zero, o_out_valid && o_out_last, o_out_byte == '0)

    `CHD_ASSERT_NOW(a_payload_fields_zero, o_out_valid && !o_out_last, w_pay_zero)

    `CHD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(w_out_word))

    `CHD_ASSERT_NOW(a_empty_after_reset, $past(!i_rst_n), !o_out_valid && !o_in_stall)

endmodule

bind http_chunked_decoder chd_checker u_chd_checker (.*);
